// ===== sv/gzcgl_pkg.sv =====
// shared widths, reset constants and control struct for the gyro zero calibrate block
package gzcgl_pkg;

    // default log2 of the calibration sample count
    localparam int SHIFT_DEF = 9;

    // field widths
    localparam int WORD_W  = 16;
    localparam int VAL_W   = 15;
    localparam int OFS_W   = 15;
    localparam int RATE_W  = 16;
    localparam int LIMIT_W = 15;

    // glitch limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd800;

    // per-request control handed from the top level to each axis
    typedef struct packed {
        logic advance;  // request moves from the input register to the result register
        logic calib;    // request is consumed by offset calibration
        logic last;     // final calibration request, offset is taken now
    } gzcgl_ctrl_t;

endpackage

// ===== sv/gzcgl_front.sv =====
// input register: scales the raw words and flips roll and yaw
module gzcgl_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [gzcgl_pkg::WORD_W-1:0]  s_word_pitch,
    input  logic signed [gzcgl_pkg::WORD_W-1:0]  s_word_roll,
    input  logic signed [gzcgl_pkg::WORD_W-1:0]  s_word_yaw,
    input  logic                                 advance,
    output logic                                 valid,
    output logic signed [gzcgl_pkg::VAL_W-1:0]   val_pitch,
    output logic signed [gzcgl_pkg::VAL_W-1:0]   val_roll,
    output logic signed [gzcgl_pkg::VAL_W-1:0]   val_yaw
);
    import gzcgl_pkg::*;

    logic                     valid_reg;
    logic signed [VAL_W-1:0]  pitch_reg;
    logic signed [VAL_W-1:0]  roll_reg;
    logic signed [VAL_W-1:0]  yaw_reg;
    logic signed [VAL_W-1:0]  pitch_next;
    logic signed [VAL_W-1:0]  roll_next;
    logic signed [VAL_W-1:0]  yaw_next;
    logic                     load;

    // register is free when empty or when its request moves on this cycle
    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    // arithmetic shift by two, roll and yaw negated
    always_comb begin
        pitch_next = VAL_W'(s_word_pitch >>> 2);
        roll_next  = -VAL_W'(s_word_roll >>> 2);
        yaw_next   = -VAL_W'(s_word_yaw >>> 2);
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign valid     = valid_reg;
    assign val_pitch = pitch_reg;
    assign val_roll  = roll_reg;
    assign val_yaw   = yaw_reg;

endmodule

// ===== sv/gzcgl_axis.sv =====
// one axis: calibration sum, zero offset, offset removal and slew clamp
module gzcgl_axis #(
    parameter int SHIFT = gzcgl_pkg::SHIFT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  gzcgl_pkg::gzcgl_ctrl_t               ctrl,
    input  logic signed [gzcgl_pkg::VAL_W-1:0]   value,
    input  logic [gzcgl_pkg::LIMIT_W-1:0]        limit,
    output logic signed [gzcgl_pkg::RATE_W-1:0]  rate
);
    import gzcgl_pkg::*;

    localparam int SUM_W  = SHIFT + VAL_W + 1;
    localparam int DIFF_W = VAL_W + 2;
    localparam int BND_W  = RATE_W + 2;
    // sum starts at half an lsb of the mean so the shift rounds
    localparam logic signed [SUM_W-1:0] SUM_BIAS = SUM_W'(1) <<< (SHIFT - 1);

    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [OFS_W-1:0]   offset_reg;
    logic signed [OFS_W-1:0]   offset_next;
    logic signed [OFS_W-1:0]   offset_use;
    logic signed [RATE_W-1:0]  prev_reg;
    logic signed [RATE_W-1:0]  prev_next;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [BND_W-1:0]   diff_ext;
    logic signed [BND_W-1:0]   lim_ext;
    logic signed [BND_W-1:0]   lo;
    logic signed [BND_W-1:0]   hi;
    logic signed [BND_W-1:0]   clamped;

    // accumulate and take the rounded mean
    always_comb begin
        sum_next    = sum_reg + SUM_W'(value);
        offset_next = sum_next[SHIFT +: OFS_W];
        offset_use  = ctrl.last ? offset_next : offset_reg;
    end

    // corrected value; during calibration the input is replaced by zero, so only the offset is subtracted
    always_comb begin
        diff     = (ctrl.calib ? DIFF_W'(0) : DIFF_W'(value)) - DIFF_W'(offset_use);
        diff_ext = BND_W'(diff);
        lim_ext  = BND_W'($signed({1'b0, limit}));
        lo       = BND_W'(prev_reg) - lim_ext;
        hi       = BND_W'(prev_reg) + lim_ext;
        if (diff_ext < lo) begin
            clamped = lo;
        end else if (diff_ext > hi) begin
            clamped = hi;
        end else begin
            clamped = diff_ext;
        end
        prev_next = clamped[RATE_W-1:0];
    end

    // axis state, previous output doubles as the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= SUM_BIAS;
            offset_reg <= '0;
            prev_reg   <= '0;
        end else if (ctrl.advance) begin
            prev_reg <= prev_next;
            if (ctrl.calib) begin
                sum_reg <= sum_next;
            end
            if (ctrl.last) begin
                offset_reg <= offset_next;
            end
        end
    end

    assign rate = prev_reg;

endmodule

// ===== sv/gyro_zero_calibrate_glitch_limit_unit.sv =====
// Gyro zero calibration with slew limit, top level.
// A request passes from the input register to the result register.
// Throughput: one request per cycle while m_ready holds; the result register is the per-axis
// previous output, so the add, subtract and clamp of each axis fit between the two registers.
// Reset (aresetn low, synchronous): 2^SHIFT calibration requests restart, sums reload the
// rounding bias, offsets and previous outputs clear, glitch limit returns to 800.
module gyro_zero_calibrate_glitch_limit_unit #(
    parameter int SHIFT = gzcgl_pkg::SHIFT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [gzcgl_pkg::LIMIT_W-1:0]        cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [gzcgl_pkg::WORD_W-1:0]  s_word_pitch,
    input  logic signed [gzcgl_pkg::WORD_W-1:0]  s_word_roll,
    input  logic signed [gzcgl_pkg::WORD_W-1:0]  s_word_yaw,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [gzcgl_pkg::RATE_W-1:0]  m_rate_pitch,
    output logic signed [gzcgl_pkg::RATE_W-1:0]  m_rate_roll,
    output logic signed [gzcgl_pkg::RATE_W-1:0]  m_rate_yaw,
    output logic                                 m_calibrating
);
    import gzcgl_pkg::*;

    localparam int CNT_W = SHIFT + 1;
    localparam logic [CNT_W-1:0] CALIB_COUNT = CNT_W'(1) << SHIFT;
    localparam logic signed [RATE_W-1:0] RATE_MAX = 16'sd16384;

    logic                     front_valid;
    logic signed [VAL_W-1:0]  val_pitch;
    logic signed [VAL_W-1:0]  val_roll;
    logic signed [VAL_W-1:0]  val_yaw;
    logic [LIMIT_W-1:0]       limit_reg;
    logic [CNT_W-1:0]         samples_left_reg;
    logic                     m_valid_reg;
    logic                     calib_reg;
    gzcgl_ctrl_t              ctrl;

    // input register
    gzcgl_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_word_pitch (s_word_pitch),
        .s_word_roll  (s_word_roll),
        .s_word_yaw   (s_word_yaw),
        .advance      (ctrl.advance),
        .valid        (front_valid),
        .val_pitch    (val_pitch),
        .val_roll     (val_roll),
        .val_yaw      (val_yaw)
    );

    // move a request on when the result register is empty or being drained
    always_comb begin
        ctrl.advance = front_valid && (!m_valid_reg || m_ready);
        ctrl.calib   = (samples_left_reg != '0);
        ctrl.last    = (samples_left_reg == CNT_W'(1));
    end

    // glitch limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // calibration counter, result valid and calibrating flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samples_left_reg <= CALIB_COUNT;
            m_valid_reg      <= 1'b0;
            calib_reg        <= 1'b0;
        end else begin
            if (ctrl.advance) begin
                m_valid_reg <= 1'b1;
                calib_reg   <= ctrl.calib;
                if (ctrl.calib) begin
                    samples_left_reg <= samples_left_reg - CNT_W'(1);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // per-axis datapath
    gzcgl_axis #(.SHIFT(SHIFT)) u_axis_pitch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .value   (val_pitch),
        .limit   (limit_reg),
        .rate    (m_rate_pitch)
    );

    gzcgl_axis #(.SHIFT(SHIFT)) u_axis_roll (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .value   (val_roll),
        .limit   (limit_reg),
        .rate    (m_rate_roll)
    );

    gzcgl_axis #(.SHIFT(SHIFT)) u_axis_yaw (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .value   (val_yaw),
        .limit   (limit_reg),
        .rate    (m_rate_yaw)
    );

    assign m_valid       = m_valid_reg;
    assign m_calibrating = calib_reg;

    // calibration counter never climbs above its start value
    assert property (@(posedge aclk) disable iff (!aresetn)
        samples_left_reg <= CALIB_COUNT)
        else $error("calibration counter out of range");

    // once calibration is over, results no longer flag it
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.advance && !ctrl.calib |=> !m_calibrating)
        else $error("calibrating flag set after calibration");

    // full input register and stalled result register must block new requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        front_valid && m_valid_reg && !m_ready |-> !s_ready)
        else $error("request accepted while pipeline is stalled");

    // results stay inside the rate range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rate_pitch <= RATE_MAX) && (m_rate_pitch >= -RATE_MAX)
                 && (m_rate_roll <= RATE_MAX) && (m_rate_roll >= -RATE_MAX)
                 && (m_rate_yaw <= RATE_MAX) && (m_rate_yaw >= -RATE_MAX))
        else $error("rate output out of range");

endmodule
